// ----- hw/rtl/dft_pkg.sv -----
// Package for the diagram format tokenizer: result record, keyword table,
// token kinds, error codes, limits, scanner states and the keyword matcher. No dependencies.
`timescale 1ns / 1ps
package dft_pkg;

	localparam int IDENT_LIMIT = 64;
	localparam int INT_LIMIT   = 20;
	localparam int REAL_LIMIT  = 32;

	localparam int KW_COUNT  = 24;
	localparam int KW_MAXLEN = 7;

	localparam logic [4:0] NO_KW = 5'd24;

	localparam logic [4:0] KIND_END   = 5'd0;
	localparam logic [4:0] KIND_IDENT = 5'd1;
	localparam logic [4:0] KIND_INT   = 5'd2;
	localparam logic [4:0] KIND_REAL  = 5'd3;
	localparam logic [4:0] KIND_SYM0  = 5'd20;
	localparam logic [4:0] KIND_ERR   = 5'd27;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_UNCLOSED = 3'd1;
	localparam logic [2:0] ERR_IDENT    = 3'd2;
	localparam logic [2:0] ERR_DOT      = 3'd3;
	localparam logic [2:0] ERR_NUMLEN   = 3'd4;
	localparam logic [2:0] ERR_SYMBOL   = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLASH,
		ST_BLOCK,
		ST_LINE,
		ST_IDENT,
		ST_NUM
	} scan_state_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [4:0]  kw;
		logic [31:0] start;
		logic [6:0]  len;
		logic [23:0] line;
		logic [2:0]  err;
		logic        last;
	} result_t;

	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} result_pair_t;

	// unused positions hold zero, which never reaches the matcher
	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
		'{"F", "O", "R", "E", "S", "T", 8'h0},
		'{"T", "Y", "P", "E", 8'h0, 8'h0, 8'h0},
		'{"R", "E", "D", "U", "C", "E", "D"},
		'{"L", "V", "L", "S", 8'h0, 8'h0, 8'h0},
		'{"D", "I", "M", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"R", "A", "N", "G", "E", 8'h0, 8'h0},
		'{"N", "N", "U", "M", 8'h0, 8'h0, 8'h0},
		'{"R", "N", "U", "M", 8'h0, 8'h0, 8'h0},
		'{"N", "O", "D", "E", "S", 8'h0, 8'h0},
		'{"L", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"R", "O", "O", "T", "S", 8'h0, 8'h0},
		'{"X", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"E", "L", "0", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"E", "L", "1", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"E", "H", "0", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"E", "H", "1", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"A", "L", "0", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"A", "L", "1", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"A", "H", "0", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"A", "H", "1", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"I", "0", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"I", "1", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"t", "r", "u", "e", 8'h0, 8'h0, 8'h0},
		'{"f", "a", "l", "s", "e", 8'h0, 8'h0}
	};

	localparam logic [6:0] KW_LEN [KW_COUNT] = '{
		7'd6, 7'd4, 7'd7, 7'd4, 7'd3, 7'd5, 7'd4, 7'd4, 7'd5, 7'd1, 7'd5, 7'd1,
		7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd3, 7'd2, 7'd2, 7'd4, 7'd5
	};

	localparam logic [4:0] KW_KIND [KW_COUNT] = '{
		5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17,
		5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18,
		5'd18, 5'd19, 5'd19
	};

	// drop every keyword that cannot hold character c at position pos
	function automatic logic [KW_COUNT-1:0] kw_match(logic [KW_COUNT-1:0] m,
			logic [6:0] pos, logic [7:0] c);
		logic [KW_COUNT-1:0] r;
		r = m;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (pos >= 7'(KW_MAXLEN)) begin
				r[i] = 1'b0;
			end else if (KW_TEXT[i][pos[2:0]] != c) begin
				r[i] = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/dft_scan.sv -----
// Scanner state and per-byte token logic of the tokenizer.
// Uses dft_pkg; gives up to two results for each accepted byte.
`timescale 1ns / 1ps
module dft_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            c,
	input  logic                  eos,
	output dft_pkg::result_pair_t res
);

	dft_pkg::scan_state_t st_q;
	logic        star_q;
	logic [6:0]  cnt_q;
	logic [31:0] off_q;
	logic [31:0] pos_q;
	logic [23:0] line_q;
	logic [23:0] kwm_q;
	logic [1:0]  lead_q;
	logic        digits_q;
	logic [1:0]  nflags_q;
	logic        halted_q;

	dft_pkg::scan_state_t st_d;
	logic        star_d;
	logic [6:0]  cnt_d;
	logic [31:0] off_d;
	logic [31:0] pos_d;
	logic [23:0] line_d;
	logic [23:0] kwm_d;
	logic [1:0]  lead_d;
	logic        digits_d;
	logic [1:0]  nflags_d;
	logic        halted_d;

	logic           is_letter, is_digit, is_end;
	logic [23:0]    line_inc;
	dft_pkg::result_t id_res, num_res;

	assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	assign is_digit  = c >= "0" && c <= "9";
	assign is_end    = eos || c == 8'h0;
	assign line_inc  = (line_q != 24'hFFFFFF) ? line_q + 24'd1 : line_q;

	// pending identifier or number as a finished token
	always_comb begin
		id_res = '0;
		id_res.start = off_q;
		id_res.len   = cnt_q;
		id_res.line  = line_q;
		id_res.err   = dft_pkg::ERR_NONE;
		id_res.kind  = dft_pkg::KIND_IDENT;
		id_res.kw    = dft_pkg::NO_KW;
		if (lead_q != 2'd0 && digits_q) begin
			id_res.kind = 5'd3 + {3'd0, lead_q};
		end else begin
			for (int i = dft_pkg::KW_COUNT - 1; i >= 0; i--) begin
				if (kwm_q[i] && dft_pkg::KW_LEN[i] == cnt_q) begin
					id_res.kind = dft_pkg::KW_KIND[i];
					id_res.kw   = 5'(i);
				end
			end
		end
		num_res = '0;
		num_res.kind  = (nflags_q != 2'd0) ? dft_pkg::KIND_REAL : dft_pkg::KIND_INT;
		num_res.kw    = dft_pkg::NO_KW;
		num_res.start = off_q;
		num_res.len   = cnt_q;
		num_res.line  = line_q;
		num_res.err   = dft_pkg::ERR_NONE;
	end

	always_comb begin
		logic             rescan, va, vb, stop;
		logic [1:0]       nf;
		dft_pkg::result_t ra, rb;
		rescan = 1'b0;
		va = 1'b0;
		vb = 1'b0;
		stop = 1'b0;
		nf = nflags_q;
		ra = '0;
		rb = '0;
		ra.kw = dft_pkg::NO_KW;
		ra.line = line_q;
		rb.kw = dft_pkg::NO_KW;
		rb.line = line_q;

		st_d     = st_q;
		star_d   = star_q;
		cnt_d    = cnt_q;
		off_d    = off_q;
		pos_d    = pos_q;
		line_d   = line_q;
		kwm_d    = kwm_q;
		lead_d   = lead_q;
		digits_d = digits_q;
		nflags_d = nflags_q;
		halted_d = halted_q;

		if (is_end) begin
			if (!halted_q) begin
				rb.kind  = dft_pkg::KIND_END;
				rb.start = pos_q;
				unique case (st_q)
					dft_pkg::ST_IDENT: begin
						ra = id_res;
						va = 1'b1;
						vb = 1'b1;
					end
					dft_pkg::ST_NUM: begin
						ra = num_res;
						va = 1'b1;
						vb = 1'b1;
					end
					dft_pkg::ST_SLASH: begin
						ra.kind = dft_pkg::KIND_ERR;
						ra.start = off_q;
						ra.len = 7'd1;
						ra.err = dft_pkg::ERR_SYMBOL;
						va = 1'b1;
					end
					dft_pkg::ST_BLOCK: begin
						ra.kind = dft_pkg::KIND_ERR;
						ra.start = off_q;
						ra.err = dft_pkg::ERR_UNCLOSED;
						va = 1'b1;
					end
					default: begin
						vb = 1'b1;
					end
				endcase
			end
			st_d = dft_pkg::ST_IDLE;
			star_d = 1'b0;
			cnt_d = '0;
			off_d = '0;
			pos_d = '0;
			line_d = 24'd1;
			kwm_d = '1;
			lead_d = '0;
			digits_d = 1'b1;
			nflags_d = '0;
			halted_d = 1'b0;
		end else if (!halted_q) begin
			unique case (st_q)
				dft_pkg::ST_IDENT: begin
					if (is_letter || is_digit || c == "_") begin
						if (cnt_q >= 7'(dft_pkg::IDENT_LIMIT)) begin
							ra.kind = dft_pkg::KIND_ERR;
							ra.start = off_q;
							ra.len = cnt_q;
							ra.err = dft_pkg::ERR_IDENT;
							va = 1'b1;
							halted_d = 1'b1;
							st_d = dft_pkg::ST_IDLE;
						end else begin
							kwm_d = dft_pkg::kw_match(kwm_q, cnt_q, c);
							if (!is_digit) digits_d = 1'b0;
							cnt_d = cnt_q + 7'd1;
						end
					end else begin
						ra = id_res;
						va = 1'b1;
						rescan = 1'b1;
					end
				end
				dft_pkg::ST_NUM: begin
					if (c == ".") begin
						nf[0] = 1'b1;
					end else if (c == "e" || c == "E") begin
						if (nflags_q[1]) stop = 1'b1;
						else nf[1] = 1'b1;
					end else if (!is_digit) begin
						if (!(nflags_q[1] && (c == "-" || c == "+"))) stop = 1'b1;
					end
					if (c == "." && nflags_q != 2'd0) begin
						ra.kind = dft_pkg::KIND_ERR;
						ra.start = off_q;
						ra.len = cnt_q;
						ra.err = dft_pkg::ERR_DOT;
						va = 1'b1;
						halted_d = 1'b1;
						st_d = dft_pkg::ST_IDLE;
					end else if (stop) begin
						ra = num_res;
						va = 1'b1;
						rescan = 1'b1;
					end else if ((!nf[0] && cnt_q >= 7'(dft_pkg::INT_LIMIT)) ||
							(nf != 2'd0 && cnt_q >= 7'(dft_pkg::REAL_LIMIT))) begin
						ra.kind = dft_pkg::KIND_ERR;
						ra.start = off_q;
						ra.len = cnt_q;
						ra.err = dft_pkg::ERR_NUMLEN;
						va = 1'b1;
						halted_d = 1'b1;
						st_d = dft_pkg::ST_IDLE;
					end else begin
						cnt_d = cnt_q + 7'd1;
						nflags_d = nf;
					end
				end
				dft_pkg::ST_SLASH: begin
					if (c == "*") begin
						st_d = dft_pkg::ST_BLOCK;
						star_d = 1'b0;
					end else if (c == "/") begin
						st_d = dft_pkg::ST_LINE;
					end else begin
						ra.kind = dft_pkg::KIND_ERR;
						ra.start = off_q;
						ra.len = 7'd1;
						ra.err = dft_pkg::ERR_SYMBOL;
						va = 1'b1;
						halted_d = 1'b1;
						st_d = dft_pkg::ST_IDLE;
					end
				end
				dft_pkg::ST_BLOCK: begin
					if (c == 8'h0A) begin
						line_d = line_inc;
						star_d = 1'b0;
					end else if (c == "/" && star_q) begin
						st_d = dft_pkg::ST_IDLE;
						star_d = 1'b0;
					end else begin
						star_d = (c == "*");
					end
				end
				dft_pkg::ST_LINE: begin
					if (c == 8'h0A) begin
						line_d = line_inc;
						st_d = dft_pkg::ST_IDLE;
					end
				end
				default: begin
					rescan = 1'b1;
				end
			endcase

			// idle scan: a fresh byte, or the byte that ended a token
			if (rescan) begin
				st_d = dft_pkg::ST_IDLE;
				rb.start = pos_q;
				rb.len = 7'd1;
				if (c == " " || c == 8'h09 || c == 8'h0D) begin
					// skip blank
				end else if (c == 8'h0A) begin
					line_d = line_inc;
				end else begin
					off_d = pos_q;
					if (is_letter) begin
						st_d = dft_pkg::ST_IDENT;
						cnt_d = 7'd1;
						kwm_d = dft_pkg::kw_match('1, 7'd0, c);
						digits_d = 1'b1;
						if (c == "N" || c == "n") lead_d = 2'd1;
						else if (c == "T" || c == "t") lead_d = 2'd2;
						else if (c == "R" || c == "r") lead_d = 2'd3;
						else lead_d = 2'd0;
					end else if (is_digit) begin
						st_d = dft_pkg::ST_NUM;
						cnt_d = 7'd1;
						nflags_d = 2'd0;
					end else if (c == "/") begin
						st_d = dft_pkg::ST_SLASH;
					end else begin
						vb = 1'b1;
						unique case (c)
							"*": rb.kind = dft_pkg::KIND_SYM0;
							"{": rb.kind = dft_pkg::KIND_SYM0 + 5'd1;
							"}": rb.kind = dft_pkg::KIND_SYM0 + 5'd2;
							":": rb.kind = dft_pkg::KIND_SYM0 + 5'd3;
							",": rb.kind = dft_pkg::KIND_SYM0 + 5'd4;
							"<": rb.kind = dft_pkg::KIND_SYM0 + 5'd5;
							">": rb.kind = dft_pkg::KIND_SYM0 + 5'd6;
							default: begin
								rb.kind = dft_pkg::KIND_ERR;
								rb.err = dft_pkg::ERR_SYMBOL;
								halted_d = 1'b1;
							end
						endcase
					end
				end
			end
			if (pos_q != 32'hFFFFFFFF) pos_d = pos_q + 32'd1;
		end

		// pack: the first live result goes into slot 0
		res.v0 = va || vb;
		res.v1 = va && vb;
		res.r0 = va ? ra : rb;
		res.r1 = rb;
		res.r0.last = !(va && vb);
		res.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= dft_pkg::ST_IDLE;
			star_q   <= 1'b0;
			cnt_q    <= '0;
			off_q    <= '0;
			pos_q    <= '0;
			line_q   <= 24'd1;
			kwm_q    <= '1;
			lead_q   <= '0;
			digits_q <= 1'b1;
			nflags_q <= '0;
			halted_q <= 1'b0;
		end else if (take) begin
			st_q     <= st_d;
			star_q   <= star_d;
			cnt_q    <= cnt_d;
			off_q    <= off_d;
			pos_q    <= pos_d;
			line_q   <= line_d;
			kwm_q    <= kwm_d;
			lead_q   <= lead_d;
			digits_q <= digits_d;
			nflags_q <= nflags_d;
			halted_q <= halted_d;
		end
	end

endmodule

// ----- hw/rtl/dft_outq.sv -----
// Four-entry result queue: takes up to two results a cycle, gives one.
// Uses dft_pkg for the result record.
`timescale 1ns / 1ps
module dft_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dft_pkg::result_pair_t din,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dft_pkg::result_t      dout
);

	dft_pkg::result_t ent_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [2:0] n_in;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign room      = cnt_q <= 3'd2;
	assign dout      = ent_q[rd_q];
	assign n_in      = push ? ({2'd0, din.v0} + {2'd0, din.v1}) : 3'd0;

	always_ff @(posedge clk) begin
		if (push && din.v0) ent_q[wr_q] <= din.r0;
		if (push && din.v1) ent_q[wr_q + 2'd1] <= din.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_in[1:0];
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + n_in - {2'd0, pop};
		end
	end

endmodule

// ----- hw/rtl/diagram_format_tokenizer_unit.sv -----
// Top level of the diagram format tokenizer: byte stream in, tokens out.
// Uses dft_pkg, dft_scan and dft_outq.
//
//  channel | dir | payload                          | marker
//  s_*     | in  | tdata[7:0] data_byte              | tlast = end_of_stream
//  m_*     | out | tdata kind,kw,start,len,line,err | tlast = last_result
//
// One byte is taken each cycle while s_tready is high; the scanner state
// updates at the transfer and its zero, one or two results land in a
// four-entry queue the same edge. Results leave on m_* in queue order.
// s_tready drops while the queue holds three or more results, so items
// that give two results sustain one result per cycle while m_tready is high.
// Reset puts the scanner between tokens, line one, and empties the queue.
`timescale 1ns / 1ps
module diagram_format_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // token_kind, keyword_index, token_start,
	                               // token_length, line_number, error_code
	output logic        m_tlast
);

	logic                  take;
	dft_pkg::result_pair_t pair;
	dft_pkg::result_t      head;

	assign take = s_tvalid && s_tready;

	dft_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.c      (s_tdata),
		.eos    (s_tlast),
		.res    (pair)
	);

	dft_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.din       (pair),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dout      (head)
	);

	assign m_tdata = {4'd0, head.err, head.line, head.len, head.start, head.kw, head.kind};
	assign m_tlast = head.last;

endmodule
